[design/mcs_pkg.sv]
// Shared types and constants for the MIDI controller smoother.
// Used by midi_controller_smoother_top; no dependencies.
package mcs_pkg;

  localparam int LEVEL_FRACTION_BITS_DEF = 10;
  localparam int COEF_BITS_DEF           = 16;

  localparam int TARGET_BITS = 14;
  localparam int BYTE7_BITS  = 7;
  localparam int SCALE_BITS  = 16;
  localparam int SCALE_SHIFT = 12;
  localparam int SAMPLE_BITS = 28;
  localparam int CFG_BITS    = 16;
  localparam int OP_BITS     = 2;

  localparam logic [CFG_BITS-1:0] DECAY_COEF_RESET = 16'd273;

  localparam logic [OP_BITS-1:0] OP_MSB    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LSB    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

[design/midi_controller_smoother_top.sv]
// MIDI 14-bit controller smoother: target assembly, one-pole smoothing, output gain.
// Bit-serial shift-add multipliers for both products. Depends on mcs_pkg.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_tvalid/in_tready | tuser: op; tdata: value, scale
//  out     | out | out_tvalid/tready   | tdata: sample
//  cfg     | in  | cfg_we              | cfg_wdata: decay_coef
//
// A tick runs COEF_BITS steps of the serial smoothing multiply, then 16 steps of
// the serial gain multiply, all through one shared accumulator.
// Reset clears target, level and flags and sets the coefficient to DECAY_COEF_RESET.
// The finished sample waits in the output register; new items are taken while
// it waits, and a following tick stalls only in ST_DONE.
module midi_controller_smoother_top #(
  parameter int LEVEL_FRACTION_BITS = mcs_pkg::LEVEL_FRACTION_BITS_DEF,
  parameter int COEF_BITS           = mcs_pkg::COEF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic [23:0] in_tdata,   // [6:0] value, [22:7] scale, [23] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [27:0] sample, [31:28] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int TB  = mcs_pkg::TARGET_BITS;
  localparam int LW  = TB + LEVEL_FRACTION_BITS;
  localparam int AW  = LW + 2;
  localparam int SB  = mcs_pkg::SCALE_BITS;
  localparam int PW  = AW + SB;
  localparam int XW  = (PW > mcs_pkg::SAMPLE_BITS + mcs_pkg::SCALE_SHIFT) ?
                       PW : mcs_pkg::SAMPLE_BITS + mcs_pkg::SCALE_SHIFT;
  localparam int CNT_MAX = ((COEF_BITS > SB) ? COEF_BITS : SB) - 1;
  localparam int CW  = $clog2(CNT_MAX + 1);
  localparam int B7  = mcs_pkg::BYTE7_BITS;

  mcs_pkg::state_t state_r, state_nxt;

  logic [mcs_pkg::CFG_BITS-1:0] coef_cfg_r;
  logic [TB-1:0]                target_r;
  logic                         lsb_seen_r;
  logic [LW-1:0]                level_r;
  logic signed [AW-1:0]         acc_r;
  logic signed [LW:0]           diff_r;
  logic [SB-1:0]                lo_r;
  logic [COEF_BITS-1:0]         coef_sh_r;
  logic [SB-1:0]                scale_sh_r;
  logic [CW-1:0]                cnt_r;
  logic                         out_valid_r;
  logic [mcs_pkg::SAMPLE_BITS-1:0] out_sample_r;

  logic [COEF_BITS-1:0] coef_eff;
  logic                 in_fire;
  logic                 out_fire;
  logic [B7-1:0]        in_value;
  logic [SB-1:0]        in_scale;
  logic signed [AW-1:0] smooth_sum;
  logic signed [AW-1:0] scale_sum;
  logic signed [AW-1:0] level_ext;
  logic [LW-1:0]        level_new;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] prod_x;
  logic                 smooth_last;
  logic                 scale_last;
  logic                 load_out;

  assign in_value = in_tdata[B7-1:0];
  assign in_scale = in_tdata[B7 +: SB];
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  generate
    if (COEF_BITS >= mcs_pkg::CFG_BITS) begin : g_coef_wide
      assign coef_eff = COEF_BITS'(coef_cfg_r);
    end else begin : g_coef_sat
      assign coef_eff = ((coef_cfg_r >> COEF_BITS) != '0) ? '1 :
                        coef_cfg_r[COEF_BITS-1:0];
    end
  endgenerate

  assign smooth_sum  = acc_r + (coef_sh_r[0] ? AW'(diff_r) : '0);
  assign level_ext   = $signed({2'b00, level_r});
  assign scale_sum   = scale_sh_r[0] ?
                       ((cnt_r == CW'(SB - 1)) ? acc_r - level_ext : acc_r + level_ext) :
                       acc_r;
  assign level_new   = level_r + LW'(smooth_sum >>> 1);
  assign prod        = $signed({acc_r, lo_r});
  assign prod_x      = XW'(prod);
  assign smooth_last = (cnt_r == CW'(COEF_BITS - 1));
  assign scale_last  = (cnt_r == CW'(SB - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcs_pkg::ST_IDLE: begin
        if (in_fire && in_tuser == mcs_pkg::OP_TICK) state_nxt = mcs_pkg::ST_SMOOTH;
      end
      mcs_pkg::ST_SMOOTH: begin
        if (smooth_last) state_nxt = mcs_pkg::ST_SCALE;
      end
      mcs_pkg::ST_SCALE: begin
        if (scale_last) state_nxt = mcs_pkg::ST_DONE;
      end
      mcs_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = mcs_pkg::ST_IDLE;
      end
      default: state_nxt = mcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mcs_pkg::ST_IDLE:   in_tready = 1'b1;
      mcs_pkg::ST_DONE:   load_out  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcs_pkg::ST_IDLE;
      coef_cfg_r  <= mcs_pkg::DECAY_COEF_RESET;
      target_r    <= '0;
      lsb_seen_r  <= 1'b0;
      level_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) coef_cfg_r <= cfg_wdata;
      if (in_fire) begin
        case (in_tuser)
          mcs_pkg::OP_MSB: begin
            target_r[TB-1:B7] <= in_value;
            if (!lsb_seen_r) target_r[B7-1:0] <= in_value;
          end
          mcs_pkg::OP_LSB: begin
            target_r[B7-1:0] <= in_value;
            lsb_seen_r       <= 1'b1;
          end
          default: ;
        endcase
      end
      case (state_r)
        mcs_pkg::ST_SMOOTH: begin
          cnt_r <= smooth_last ? '0 : cnt_r + 1'b1;
          if (smooth_last) level_r <= level_new;
        end
        mcs_pkg::ST_SCALE: cnt_r <= scale_last ? '0 : cnt_r + 1'b1;
        default: cnt_r <= '0;
      endcase
      if (load_out) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      diff_r     <= $signed({1'b0, target_r, LEVEL_FRACTION_BITS'(0)}) -
                    $signed({1'b0, level_r});
      coef_sh_r  <= coef_eff;
      scale_sh_r <= in_scale;
      acc_r      <= '0;
    end
    case (state_r)
      mcs_pkg::ST_SMOOTH: begin
        coef_sh_r <= coef_sh_r >> 1;
        if (smooth_last) acc_r <= '0;
        else acc_r <= smooth_sum >>> 1;
      end
      mcs_pkg::ST_SCALE: begin
        scale_sh_r <= scale_sh_r >> 1;
        acc_r      <= scale_sum >>> 1;
        lo_r       <= {scale_sum[0], lo_r[SB-1:1]};
      end
      default: ;
    endcase
    if (load_out) out_sample_r <= prod_x[mcs_pkg::SCALE_SHIFT +: mcs_pkg::SAMPLE_BITS];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_sample_r};

`ifndef SYNTHESIS
  a_write_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser != mcs_pkg::OP_TICK |=> $stable(level_r))
    else $error("level changed on a non-tick item");
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == mcs_pkg::OP_TICK |=> state_r == mcs_pkg::ST_SMOOTH)
    else $error("tick did not start smoothing");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mcs_pkg::ST_SMOOTH |-> cnt_r <= CW'(COEF_BITS - 1))
    else $error("smoothing counter out of range");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mcs_pkg::ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

[tb/sv/midi_controller_smoother_top_tb.sv]
// Self-checking testbench for midi_controller_smoother_top: target assembly, smoothing, gain.
// Streams directed and random items, predicts every sample and compares. Depends on mcs_pkg.
module midi_controller_smoother_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT = 700;
  localparam int HOLD_LEN = 500;
  localparam int PHASE_ITEMS = 265;

  typedef struct {
    logic [mcs_pkg::OP_BITS-1:0]           op;
    logic [mcs_pkg::BYTE7_BITS-1:0]        value;
    logic signed [mcs_pkg::SCALE_BITS-1:0] scale;
  } ctl_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  midi_controller_smoother_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  ctl_item_t                              pending[$];
  logic signed [mcs_pkg::SAMPLE_BITS-1:0] samples_due[$];
  ctl_item_t                              on_bus;
  int                                     items_queued = 0;
  int                                     items_taken = 0;
  int                                     error_count = 0;
  int                                     send_gap = 0;
  int                                     recv_gap = 0;
  int                                     hold_left = 0;
  bit                                     hold_done = 1'b0;
  bit                                     quiet = 1'b0;
  int                                     idle_cycles = 0;

  // predictor state
  logic [mcs_pkg::CFG_BITS-1:0]    decay = mcs_pkg::DECAY_COEF_RESET;
  logic [mcs_pkg::TARGET_BITS-1:0] target = '0;
  bit                              lsb_seen = 1'b0;
  longint unsigned                 level = 0;

  function automatic void track_controller(input ctl_item_t it);
    longint unsigned unity;
    longint unsigned c;
    longint signed   prod;
    longint signed   q;
    unity = longint'(1) << mcs_pkg::COEF_BITS_DEF;
    case (it.op)
      mcs_pkg::OP_MSB: begin
        if (lsb_seen) target[13:7] = it.value;
        else target = {it.value, it.value};
      end
      mcs_pkg::OP_LSB: begin
        target[6:0] = it.value;
        lsb_seen = 1'b1;
      end
      mcs_pkg::OP_TICK: begin
        c = decay;
        if (c >= unity) c = unity - 1;
        level = (level * (unity - c) +
                 ((longint'(target) << mcs_pkg::LEVEL_FRACTION_BITS_DEF) * c))
                >> mcs_pkg::COEF_BITS_DEF;
        prod = longint'(level) * longint'(it.scale);
        q = prod >>> mcs_pkg::SCALE_SHIFT;
        samples_due.push_back(q[mcs_pkg::SAMPLE_BITS-1:0]);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [mcs_pkg::SAMPLE_BITS-1:0] got,
                                 input logic [mcs_pkg::SAMPLE_BITS-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want), $time);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin : drive
    ctl_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_controller(on_bus);
        items_taken <= items_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          on_bus <= nxt;
          in_tvalid <= 1'b1;
          in_tuser <= nxt.op;
          in_tdata <= {1'b0, nxt.scale, nxt.value};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin : sample_check
    logic signed [mcs_pkg::SAMPLE_BITS-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          report_mismatch("unexpected sample", out_tdata[mcs_pkg::SAMPLE_BITS-1:0], '0);
        end else begin
          want = samples_due.pop_front();
          if (out_tdata[mcs_pkg::SAMPLE_BITS-1:0] !== want)
            report_mismatch("sample", out_tdata[mcs_pkg::SAMPLE_BITS-1:0], want);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && items_taken >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic [mcs_pkg::OP_BITS-1:0] op,
                           input logic [mcs_pkg::BYTE7_BITS-1:0] value,
                           input logic signed [mcs_pkg::SCALE_BITS-1:0] scale);
    ctl_item_t it;
    it.op = op;
    it.value = value;
    it.scale = scale;
    pending.push_back(it);
    items_queued++;
  endtask

  function automatic logic [mcs_pkg::BYTE7_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return mcs_pkg::BYTE7_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [mcs_pkg::SCALE_BITS-1:0] pick_scale();
    case ($urandom_range(0, 11))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd4096;
      3: return 16'sd0;
      4: return -16'sd1;
      default: return mcs_pkg::SCALE_BITS'($urandom);
    endcase
  endfunction

  // mostly well-formed controller updates followed by runs of ticks, some noise
  task automatic queue_random(input int n);
    int made;
    int ticks;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        push_item(mcs_pkg::OP_MSB, pick_value(), pick_scale());
        made++;
        if ($urandom_range(0, 1) == 0) begin
          push_item(mcs_pkg::OP_LSB, pick_value(), pick_scale());
          made++;
        end
        ticks = $urandom_range(1, 10);
        repeat (ticks) push_item(mcs_pkg::OP_TICK, pick_value(), pick_scale());
        made += ticks;
      end else begin
        push_item(mcs_pkg::OP_BITS'($urandom_range(0, 3)), pick_value(), pick_scale());
        made++;
      end
    end
  endtask

  task automatic drain();
    while (items_taken != items_queued || samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_decay(input logic [mcs_pkg::CFG_BITS-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    decay = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // before any LSB: MSB byte fills both halves
    push_item(mcs_pkg::OP_MSB, 7'd127, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd4096);
    push_item(mcs_pkg::OP_TICK, 7'd127, 16'sd32767);
    push_item(mcs_pkg::OP_TICK, 7'd0, -16'sd32768);
    push_item(mcs_pkg::OP_UNUSED, 7'd127, -16'sd1);
    push_item(mcs_pkg::OP_TICK, 7'd0, -16'sd1);
    push_item(mcs_pkg::OP_MSB, 7'd0, 16'sd32767);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd0);
    drain();

    set_decay(16'hFFFF);
    push_item(mcs_pkg::OP_MSB, 7'd127, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd4096);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd32767);
    push_item(mcs_pkg::OP_TICK, 7'd0, -16'sd32768);
    push_item(mcs_pkg::OP_TICK, 7'd0, -16'sd4096);
    push_item(mcs_pkg::OP_LSB, 7'd0, -16'sd32768);
    push_item(mcs_pkg::OP_MSB, 7'd127, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd4096);
    push_item(mcs_pkg::OP_LSB, 7'd127, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd1);
    push_item(mcs_pkg::OP_MSB, 7'd0, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd127, 16'sd4096);
    drain();

    // zero coefficient holds the level
    set_decay(16'h0000);
    push_item(mcs_pkg::OP_MSB, 7'd127, 16'sd0);
    push_item(mcs_pkg::OP_TICK, 7'd0, 16'sd4096);
    push_item(mcs_pkg::OP_TICK, 7'd0, -16'sd4096);
    drain();

    set_decay(16'd1);
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(mcs_pkg::DECAY_COEF_RESET);
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(16'hFFFF);
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(mcs_pkg::CFG_BITS'($urandom_range(1, 65535)));
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(16'h8000);
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(mcs_pkg::CFG_BITS'($urandom_range(1000, 65535)));
    queue_random(PHASE_ITEMS);
    drain();
    set_decay(mcs_pkg::CFG_BITS'($urandom_range(1, 65535)));
    quiet <= 1'b1;
    queue_random(PHASE_ITEMS);
    drain();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
